// File: design/query_text_lexer_assert.svh
// ----------------------------------------------------------------------------
// query_text_lexer assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef QUERY_TEXT_LEXER_ASSERT_SVH
`define QUERY_TEXT_LEXER_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define QTL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("query_text_lexer assertion failed");
// boolean expression must never be true outside reset
`define QTL_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `QTL_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define QTL_ASSERT(lbl, clk, rst_n, prop)
`define QTL_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: design/qtl_pkg.sv
// ----------------------------------------------------------------------------
// qtl_pkg
// item types, token kinds, scan modes and character classes of the lexer
// ----------------------------------------------------------------------------
package qtl_pkg;

  typedef enum logic [3:0] {
    KIND_EOF       = 4'd0,
    KIND_STAR      = 4'd1,
    KIND_DOT       = 4'd2,
    KIND_COMMA     = 4'd3,
    KIND_SEMICOLON = 4'd4,
    KIND_LPAREN    = 4'd5,
    KIND_RPAREN    = 4'd6,
    KIND_LBRACE    = 4'd7,
    KIND_RBRACE    = 4'd8,
    KIND_STRING    = 4'd9,
    KIND_NUMBER    = 4'd10,
    KIND_IDENT     = 4'd11,
    KIND_ERROR     = 4'd12
  } kind_e;

  typedef enum logic [6:0] {
    MODE_BETWEEN = 7'b000_0001,
    MODE_COMMENT = 7'b000_0010,
    MODE_STRING  = 7'b000_0100,
    MODE_NUMBER  = 7'b000_1000,
    MODE_IDENT   = 7'b001_0000,
    MODE_ERROR   = 7'b010_0000,
    MODE_DONE    = 7'b100_0000
  } mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       final_char;
  } in_item_t;

  typedef struct packed {
    kind_e        kind;
    logic [63:0]  number_value;
    logic [15:0]  token_length;
    logic [31:0]  start_offset;
    logic [19:0]  start_line;
    logic [15:0]  start_column;
    logic         run_end;
  } out_item_t;

  localparam int unsigned GroupDepth = 3;

  // records caused by one character, in delivery order
  typedef struct packed {
    logic [1:0]                       cnt;
    out_item_t [GroupDepth-1:0]       rec;
  } group_t;

  localparam logic [19:0] LineMax = 20'hF_FFFF;
  localparam logic [15:0] ColMax  = 16'hFFFF;

  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  endfunction

  // KIND_EOF when the character is no punctuation token
  function automatic kind_e punct_kind(input logic [7:0] c);
    kind_e k;
    case (c)
      ChStar:   k = KIND_STAR;
      ChDot:    k = KIND_DOT;
      ChComma:  k = KIND_COMMA;
      ChSemi:   k = KIND_SEMICOLON;
      ChLParen: k = KIND_LPAREN;
      ChRParen: k = KIND_RPAREN;
      ChLBrace: k = KIND_LBRACE;
      ChRBrace: k = KIND_RBRACE;
      default:  k = KIND_EOF;
    endcase
    return k;
  endfunction

endpackage

// File: design/qtl_scan.sv
// ----------------------------------------------------------------------------
// qtl_scan
// lexer state and one-character step, producing the record group per item
// ----------------------------------------------------------------------------
module qtl_scan #(
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  qtl_pkg::in_item_t item_i,
  output qtl_pkg::group_t   group_o
);
  import qtl_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

  mode_e                  mode_q, mode_d;
  logic [7:0]             quote_q, quote_d;
  logic [63:0]            val_q, val_d;
  logic [LENGTH_BITS-1:0] len_q, len_d, len_inc;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [19:0]            line_q, line_d;
  logic [15:0]            col_q, col_d;
  logic [OFFSET_BITS-1:0] soff_q, soff_d;
  logic [19:0]            sline_q, sline_d;
  logic [15:0]            scol_q, scol_d;

  logic [7:0]  c;
  logic        fin, active, done;
  logic [63:0] val_step;
  kind_e       pk;
  logic        a_v, b_v, p_v, e_v;
  kind_e       a_kind, b_kind, p_kind;
  out_item_t   cand [4];
  logic        cv   [4];
  out_item_t   slot [4];
  logic [2:0]  n;

  assign c        = item_i.ch;
  assign fin      = item_i.final_char;
  assign pk       = punct_kind(c);
  assign len_inc  = (len_q == LenMax) ? len_q : len_q + LENGTH_BITS'(1);
  // value * 10 + digit, as two shifted copies
  assign val_step = {val_q[60:0], 3'b000} + {val_q[62:0], 1'b0} + {56'd0, c - ChZero};

  always_comb begin
    mode_d  = mode_q;
    quote_d = quote_q;
    val_d   = val_q;
    len_d   = len_q;
    pos_d   = pos_q;
    line_d  = line_q;
    col_d   = col_q;
    soff_d  = soff_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    a_v     = 1'b0;
    a_kind  = KIND_EOF;
    b_v     = 1'b0;
    b_kind  = KIND_EOF;
    p_v     = 1'b0;
    p_kind  = KIND_EOF;
    e_v     = 1'b0;
    done    = 1'b0;
    active  = take_i && (mode_q != MODE_ERROR) && (mode_q != MODE_DONE);

    if (active) begin
      // continue or close the token in progress
      case (mode_q)
        MODE_NUMBER: begin
          if (is_digit(c) || (c == ChUnder)) begin
            if (c != ChUnder) val_d = val_step;
            len_d = len_inc;
            done  = 1'b1;
          end else begin
            a_v    = 1'b1;
            a_kind = KIND_NUMBER;
            mode_d = MODE_BETWEEN;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c) || (c == ChUnder)) begin
            len_d = len_inc;
            done  = 1'b1;
          end else begin
            a_v    = 1'b1;
            a_kind = KIND_IDENT;
            mode_d = MODE_BETWEEN;
          end
        end
        MODE_STRING: begin
          if (c == quote_q) begin
            a_v    = 1'b1;
            a_kind = KIND_STRING;
            mode_d = MODE_BETWEEN;
          end else begin
            len_d = len_inc;
          end
          done = 1'b1;
        end
        MODE_COMMENT: begin
          if (c == ChLf) mode_d = MODE_BETWEEN;
          else           done   = 1'b1;
        end
        default: ;
      endcase

      // start of a new token
      if (!done && (mode_d == MODE_BETWEEN)) begin
        if (is_blank(c)) begin
          mode_d = MODE_BETWEEN;
        end else if (c == ChHash) begin
          mode_d = MODE_COMMENT;
        end else begin
          soff_d  = pos_q;
          sline_d = line_q;
          scol_d  = col_q;
          if (pk != KIND_EOF) begin
            b_v    = 1'b1;
            b_kind = pk;
          end else if ((c == ChDquote) || (c == ChSquote)) begin
            quote_d = c;
            len_d   = '0;
            mode_d  = MODE_STRING;
          end else if (is_digit(c)) begin
            val_d  = {56'd0, c - ChZero};
            len_d  = LENGTH_BITS'(1);
            mode_d = MODE_NUMBER;
          end else if (is_alpha(c)) begin
            val_d  = '0;
            len_d  = LENGTH_BITS'(1);
            mode_d = MODE_IDENT;
          end else begin
            b_v    = 1'b1;
            b_kind = KIND_ERROR;
            mode_d = MODE_ERROR;
          end
        end
      end

      // position tracking
      if (c == ChLf) begin
        if (line_q != LineMax) line_d = line_q + 20'd1;
        col_d = 16'd1;
      end else if (col_q != ColMax) begin
        col_d = col_q + 16'd1;
      end
      pos_d = pos_q + OFFSET_BITS'(1);

      // end of input
      if (fin && (mode_d != MODE_ERROR)) begin
        if (mode_d == MODE_STRING) begin
          p_v    = 1'b1;
          p_kind = KIND_ERROR;
          mode_d = MODE_ERROR;
        end else begin
          if (mode_d == MODE_NUMBER) begin
            p_v    = 1'b1;
            p_kind = KIND_NUMBER;
          end else if (mode_d == MODE_IDENT) begin
            p_v    = 1'b1;
            p_kind = KIND_IDENT;
          end
          e_v    = 1'b1;
          mode_d = MODE_DONE;
        end
      end
    end
  end

  // candidate records in emission order
  always_comb begin
    cand[0].kind         = a_kind;
    cand[0].number_value = (a_kind == KIND_NUMBER) ? val_q : 64'd0;
    cand[0].token_length = 16'(len_q);
    cand[0].start_offset = 32'(soff_q);
    cand[0].start_line   = sline_q;
    cand[0].start_column = scol_q;
    cand[0].run_end      = 1'b0;
    cv[0]                = a_v;

    cand[1].kind         = b_kind;
    cand[1].number_value = 64'd0;
    cand[1].token_length = 16'd1;
    cand[1].start_offset = 32'(pos_q);
    cand[1].start_line   = line_q;
    cand[1].start_column = col_q;
    cand[1].run_end      = 1'b0;
    cv[1]                = b_v;

    cand[2].kind         = p_kind;
    cand[2].number_value = (p_kind == KIND_NUMBER) ? val_d : 64'd0;
    cand[2].token_length = 16'(len_d);
    cand[2].start_offset = 32'(soff_d);
    cand[2].start_line   = sline_d;
    cand[2].start_column = scol_d;
    cand[2].run_end      = 1'b0;
    cv[2]                = p_v;

    cand[3].kind         = KIND_EOF;
    cand[3].number_value = 64'd0;
    cand[3].token_length = 16'd0;
    cand[3].start_offset = 32'(pos_d);
    cand[3].start_line   = line_d;
    cand[3].start_column = col_d;
    cand[3].run_end      = 1'b0;
    cv[3]                = e_v;
  end

  // pack valid candidates to the front, at most three ever valid
  always_comb begin
    for (int i = 0; i < 4; i++) slot[i] = cand[3];
    n = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i]) begin
        slot[n[1:0]] = cand[i];
        n            = n + 3'd1;
      end
    end
    group_o.cnt = n[1:0];
    for (int i = 0; i < GroupDepth; i++) begin
      group_o.rec[i]         = slot[i];
      group_o.rec[i].run_end = (3'(i) + 3'd1) == n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BETWEEN;
      quote_q <= '0;
      val_q   <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      line_q  <= 20'd1;
      col_q   <= '0;
      soff_q  <= '0;
      sline_q <= 20'd1;
      scol_q  <= '0;
    end else if (active) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      val_q   <= val_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      col_q   <= col_d;
      soff_q  <= soff_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
    end
  end

endmodule

// File: design/qtl_group_buf.sv
// ----------------------------------------------------------------------------
// qtl_group_buf
// result register holding the records of one character, sent one per cycle unless stalled
// ----------------------------------------------------------------------------
module qtl_group_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  qtl_pkg::group_t    group_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qtl_pkg::out_item_t out_item_o
);
  import qtl_pkg::*;

  out_item_t [GroupDepth-1:0] rec_q;
  logic [1:0]                 rd_q;
  logic [1:0]                 left_q;
  logic                       pop;

  assign out_valid_o = (left_q != 2'd0);
  assign out_item_o  = rec_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // free when empty or the last record leaves at this edge
  assign free_o      = (left_q == 2'd0) || ((left_q == 2'd1) && pop);

  always_ff @(posedge clk_i) begin
    if (load_i) rec_q <= group_i.rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      left_q <= '0;
    end else if (load_i) begin
      rd_q   <= '0;
      left_q <= group_i.cnt;
    end else if (pop) begin
      rd_q   <= rd_q + 2'd1;
      left_q <= left_q - 2'd1;
    end
  end

endmodule

// File: design/query_text_lexer.sv
// ----------------------------------------------------------------------------
// query_text_lexer
// result path: the first record of a character is offered from the result register;
//   the input register holds it, then the scan step loads its group there once free
// throughput: one character per cycle while the output is not stalled and each
//   yields at most one record; otherwise the next waits for the last record to leave
// reset: asynchronous, active low; scanning restarts between tokens at line 1
// ----------------------------------------------------------------------------
`include "query_text_lexer_assert.svh"

module query_text_lexer #(
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qtl_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qtl_pkg::out_item_t out_item_o
);
  import qtl_pkg::*;

  // input register
  logic     in_valid_q;
  in_item_t in_item_q;

  // scan step and result register handshake
  logic   take;
  logic   buf_free;
  group_t group;

  // a waiting character moves on once the result register can take its group
  assign take       = in_valid_q && buf_free;
  assign in_stall_o = in_valid_q && !take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload only, loads with each accepted item
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_item_q <= in_item_i;
  end

  // lexer state and per-character step
  qtl_scan #(
    .LENGTH_BITS (LENGTH_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .item_i  (in_item_q),
    .group_o (group)
  );

  // up to three records per character, drained in order
  qtl_group_buf u_group_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .group_i     (group),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // the input only stalls while a character waits in the input register
  `QTL_ASSERT_NEVER(a_stall_needs_item, clk_i, rst_ni, in_stall_o && !in_valid_q)
  // eof and error records always close the run of their character
  `QTL_ASSERT(a_terminal_is_last, clk_i, rst_ni, (out_valid_o && ((out_item_o.kind == KIND_EOF) || (out_item_o.kind == KIND_ERROR))) |-> out_item_o.run_end)
  // nothing follows a delivered eof
  `QTL_ASSERT(a_quiet_after_eof, clk_i, rst_ni, (out_valid_o && !out_stall_i && (out_item_o.kind == KIND_EOF)) |=> !out_valid_o)

endmodule

// File: tb/sv/query_text_lexer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// query_text_lexer_checker
// watches both channels, predicts the token records of every accepted
// character and compares each delivered record with the oldest prediction
// ----------------------------------------------------------------------------
module query_text_lexer_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  qtl_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  qtl_pkg::out_item_t out_item_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  import qtl_pkg::*;

  // scanner state as the lexer keeps it
  mode_e       scan_mode;
  logic [7:0]  quote_ch;
  logic [63:0] accum_val;
  logic [15:0] accum_len;
  logic [31:0] pos_cnt;
  logic [19:0] line_cnt;
  logic [15:0] col_cnt;
  logic [31:0] tok_off;
  logic [19:0] tok_line;
  logic [15:0] tok_col;

  // records of the character being lexed, then the queue of predicted tokens
  out_item_t   rec_group [GroupDepth];
  int unsigned rec_count;
  out_item_t   token_queue [$];

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic letter_char(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  endfunction

  function automatic kind_e punct_of(input logic [7:0] c);
    case (c)
      ChStar:   return KIND_STAR;
      ChDot:    return KIND_DOT;
      ChComma:  return KIND_COMMA;
      ChSemi:   return KIND_SEMICOLON;
      ChLParen: return KIND_LPAREN;
      ChRParen: return KIND_RPAREN;
      ChLBrace: return KIND_LBRACE;
      ChRBrace: return KIND_RBRACE;
      default:  return KIND_EOF;
    endcase
  endfunction

  function automatic void add_record(input kind_e k, input logic [63:0] v,
                                     input logic [15:0] len, input logic [31:0] off,
                                     input logic [19:0] ln, input logic [15:0] col);
    out_item_t r;
    r.kind         = k;
    r.number_value = v;
    r.token_length = len;
    r.start_offset = off;
    r.start_line   = ln;
    r.start_column = col;
    r.run_end      = 1'b0;
    if (rec_count < GroupDepth) begin
      rec_group[rec_count] = r;
      rec_count++;
    end
  endfunction

  // token that began earlier and is closed now
  function automatic void add_pending(input kind_e k, input logic [63:0] v);
    add_record(k, v, accum_len, tok_off, tok_line, tok_col);
  endfunction

  function automatic void mark_start();
    tok_off  = pos_cnt;
    tok_line = line_cnt;
    tok_col  = col_cnt;
  endfunction

  function automatic void bump_len();
    if (accum_len != 16'hFFFF) accum_len++;
  endfunction

  function automatic void lex_char(input logic [7:0] c, input logic fin);
    logic       consumed;
    kind_e      pk;
    logic [7:0] digit;
    rec_count = 0;
    consumed  = 1'b0;
    digit     = c - ChZero;
    if (scan_mode == MODE_ERROR || scan_mode == MODE_DONE) return;

    case (scan_mode)
      MODE_NUMBER: begin
        if (digit_char(c) || c == ChUnder) begin
          if (c != ChUnder) accum_val = accum_val * 64'd10 + {56'd0, digit};
          bump_len();
          consumed = 1'b1;
        end else begin
          add_pending(KIND_NUMBER, accum_val);
          scan_mode = MODE_BETWEEN;
        end
      end
      MODE_IDENT: begin
        if (letter_char(c) || digit_char(c) || c == ChUnder) begin
          bump_len();
          consumed = 1'b1;
        end else begin
          add_pending(KIND_IDENT, 64'd0);
          scan_mode = MODE_BETWEEN;
        end
      end
      MODE_STRING: begin
        if (c == quote_ch) begin
          add_pending(KIND_STRING, 64'd0);
          scan_mode = MODE_BETWEEN;
        end else begin
          bump_len();
        end
        consumed = 1'b1;
      end
      MODE_COMMENT: begin
        if (c == ChLf) scan_mode = MODE_BETWEEN;
        else consumed = 1'b1;
      end
      default: ;
    endcase

    if (!consumed && scan_mode == MODE_BETWEEN) begin
      pk = punct_of(c);
      if (blank_char(c)) begin
      end else if (c == ChHash) begin
        scan_mode = MODE_COMMENT;
      end else if (pk != KIND_EOF) begin
        mark_start();
        add_record(pk, 64'd0, 16'd1, pos_cnt, line_cnt, col_cnt);
      end else if (c == ChDquote || c == ChSquote) begin
        mark_start();
        quote_ch  = c;
        accum_len = 16'd0;
        scan_mode = MODE_STRING;
      end else if (digit_char(c)) begin
        mark_start();
        accum_val = {56'd0, digit};
        accum_len = 16'd1;
        scan_mode = MODE_NUMBER;
      end else if (letter_char(c)) begin
        mark_start();
        accum_val = 64'd0;
        accum_len = 16'd1;
        scan_mode = MODE_IDENT;
      end else begin
        mark_start();
        add_record(KIND_ERROR, 64'd0, 16'd1, pos_cnt, line_cnt, col_cnt);
        scan_mode = MODE_ERROR;
      end
    end

    if (c == ChLf) begin
      if (line_cnt < LineMax) line_cnt++;
      col_cnt = 16'd1;
    end else if (col_cnt < ColMax) begin
      col_cnt++;
    end
    pos_cnt++;

    if (fin && scan_mode != MODE_ERROR) begin
      if (scan_mode == MODE_STRING) begin
        add_pending(KIND_ERROR, 64'd0);
        scan_mode = MODE_ERROR;
      end else begin
        if (scan_mode == MODE_NUMBER) add_pending(KIND_NUMBER, accum_val);
        else if (scan_mode == MODE_IDENT) add_pending(KIND_IDENT, 64'd0);
        add_record(KIND_EOF, 64'd0, 16'd0, pos_cnt, line_cnt, col_cnt);
        scan_mode = MODE_DONE;
      end
    end

    for (int unsigned i = 0; i < rec_count; i++) begin
      if (i == rec_count - 1) rec_group[i].run_end = 1'b1;
      token_queue.push_back(rec_group[i]);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      scan_mode = MODE_BETWEEN;
      quote_ch  = 8'd0;
      accum_val = 64'd0;
      accum_len = 16'd0;
      pos_cnt   = 32'd0;
      line_cnt  = 20'd1;
      col_cnt   = 16'd0;
      tok_off   = 32'd0;
      tok_line  = 20'd1;
      tok_col   = 16'd0;
      token_queue.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) lex_char(in_item_i.ch, in_item_i.final_char);
      if (out_valid_i && !out_stall_i) begin
        if (token_queue.size() == 0) begin
          $display("%0t unexpected record expected none actual %0h", $time, out_item_i);
          fail_count_o++;
        end else begin
          want = token_queue.pop_front();
          check_field("kind", {60'd0, want.kind}, {60'd0, out_item_i.kind});
          check_field("number_value", want.number_value, out_item_i.number_value);
          check_field("token_length", {48'd0, want.token_length},
                      {48'd0, out_item_i.token_length});
          check_field("start_offset", {32'd0, want.start_offset},
                      {32'd0, out_item_i.start_offset});
          check_field("start_line", {44'd0, want.start_line}, {44'd0, out_item_i.start_line});
          check_field("start_column", {48'd0, want.start_column},
                      {48'd0, out_item_i.start_column});
          check_field("run_end", {63'd0, want.run_end}, {63'd0, out_item_i.run_end});
        end
      end
      pending_o = token_queue.size();
    end
  end

endmodule

// File: tb/sv/query_text_lexer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// query_text_lexer_tb
// feeds the lexer a short hand-written text and then a long random stream of
// well-formed tokens, closed by one randomly chosen ending; a checker beside
// the block predicts and compares every token record
// ----------------------------------------------------------------------------
module query_text_lexer_tb;
  import qtl_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 395;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChLowerA = 8'h61;

  // every punctuation kind, an empty string, a string holding the other quote
  // and a high byte, a number with an underscore ended by punctuation, an
  // identifier ended by a blank and a comment holding a high byte
  localparam int unsigned DirectedLen = 28;
  localparam logic [DirectedLen*8-1:0] DirectedText = {
    ChStar, ChDot, ChComma, ChSemi, ChLParen, ChRParen, ChLBrace, ChRBrace,
    ChTab, ChSquote, ChSquote, ChDquote, 8'hFF, ChSquote, ChDquote, ChSpace,
    ChNine, ChUnder, ChZero, ChComma, 8'h61, 8'h5A, ChUnder, ChNine,
    ChCr, ChHash, 8'h80, ChLf
  };

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent_count = 0;
  int unsigned quiet_left = 0;

  query_text_lexer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  query_text_lexer_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sender idle time: mostly none or short, now and then long, and quiet
  // stretches of back-to-back items
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_left != 0) begin
      quiet_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet_left = $urandom_range(20, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // any byte but one, so string and comment bodies reach the high bytes
  function automatic logic [7:0] body_byte(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == avoid) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] any_letter();
    return ($urandom_range(0, 1) ? ChUpperA : ChLowerA) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_digit();
    return ChZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] any_quote();
    return $urandom_range(0, 1) ? ChDquote : ChSquote;
  endfunction

  function automatic logic [7:0] any_punct();
    case ($urandom_range(0, 7))
      0:       return ChStar;
      1:       return ChDot;
      2:       return ChComma;
      3:       return ChSemi;
      4:       return ChLParen;
      5:       return ChRParen;
      6:       return ChLBrace;
      default: return ChRBrace;
    endcase
  endfunction

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 3))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChCr;
      default: return ChLf;
    endcase
  endfunction

  // bytes that cannot start a token
  function automatic logic [7:0] bad_byte();
    case ($urandom_range(0, 4))
      0:       return ChUnder;
      1:       return 8'h40;
      2:       return 8'h00;
      3:       return 8'h7E;
      default: return {1'b1, 7'($urandom_range(0, 127))};
    endcase
  endfunction

  // offer one item after a random gap and hold it until accepted
  task automatic feed_char(input logic [7:0] c, input logic fin);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{ch: c, final_char: fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // hold the sender until every predicted record has been delivered
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic feed_number(input int unsigned len);
    feed_char(any_digit(), 1'b0);
    for (int unsigned i = 1; i < len; i++)
      feed_char(($urandom_range(0, 4) == 0) ? ChUnder : any_digit(), 1'b0);
  endtask

  task automatic feed_ident(input int unsigned len);
    int unsigned roll;
    feed_char(any_letter(), 1'b0);
    for (int unsigned i = 1; i < len; i++) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) feed_char(any_letter(), 1'b0);
      else if (roll < 9) feed_char(any_digit(), 1'b0);
      else feed_char(ChUnder, 1'b0);
    end
  endtask

  task automatic feed_string();
    logic [7:0] q;
    int unsigned len;
    q   = any_quote();
    len = $urandom_range(0, 6);
    feed_char(q, 1'b0);
    repeat (len) feed_char(body_byte(q), 1'b0);
    feed_char(q, 1'b0);
  endtask

  task automatic feed_comment();
    int unsigned len;
    len = $urandom_range(0, 8);
    feed_char(ChHash, 1'b0);
    repeat (len) feed_char(body_byte(ChLf), 1'b0);
    feed_char(ChLf, 1'b0);
  endtask

  // mostly well-formed text with random content; a word that the next token
  // would extend gets a separator first
  task automatic random_text();
    int unsigned goal;
    int unsigned pick;
    int unsigned word_open;
    logic        drained_once;
    goal         = sent_count + RandomItems;
    word_open    = 0;
    drained_once = 1'b0;
    while (sent_count < goal) begin
      pick = $urandom_range(0, 99);
      if ((pick >= 58 && word_open != 0) || (pick >= 78 && word_open == 2)) begin
        if ($urandom_range(0, 1)) feed_char(any_punct(), 1'b0);
        else feed_char(any_blank(), 1'b0);
      end
      word_open = 0;
      if (pick < 20) begin
        feed_char(any_punct(), 1'b0);
      end else if (pick < 35) begin
        feed_char(any_blank(), 1'b0);
      end else if (pick < 43) begin
        feed_comment();
      end else if (pick < 58) begin
        feed_string();
      end else if (pick < 78) begin
        // long numbers may wrap the 64-bit value
        if ($urandom_range(0, 9) == 0) feed_number($urandom_range(20, 24));
        else feed_number($urandom_range(1, 6));
        word_open = 1;
      end else begin
        feed_ident($urandom_range(1, 8));
        word_open = 2;
      end
      if (!drained_once && sent_count >= goal - RandomItems / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end else if ($urandom_range(0, 60) == 0) begin
        wait_drained();
      end
    end
  endtask

  // one way of closing the input per run, then a few bytes that the lexer
  // must ignore
  task automatic feed_ending();
    logic [7:0] q;
    int unsigned len;
    feed_char(ChSpace, 1'b0);
    case ($urandom_range(0, 5))
      0: feed_char(any_blank(), 1'b1);
      1: begin
        // number still open at end of input
        feed_number($urandom_range(1, 4));
        feed_char(any_digit(), 1'b1);
      end
      2: begin
        // open identifier closed by punctuation on the last byte
        feed_ident($urandom_range(1, 4));
        feed_char(any_punct(), 1'b1);
      end
      3: begin
        // string never closed
        q   = any_quote();
        len = $urandom_range(0, 4);
        if (len == 0) begin
          feed_char(q, 1'b1);
        end else begin
          feed_char(q, 1'b0);
          repeat (len - 1) feed_char(body_byte(q), 1'b0);
          feed_char(body_byte(q), 1'b1);
        end
      end
      4: feed_char(bad_byte(), 1'($urandom_range(0, 1)));
      default: begin
        // end of input inside a comment
        feed_char(ChHash, 1'b0);
        feed_char(body_byte(ChLf), 1'b1);
      end
    endcase
    repeat ($urandom_range(3, 6))
      feed_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // output stall: stretches of free flow, short stalls and a few long ones
  initial begin : stall_gen
    int unsigned stall_left;
    int unsigned free_left;
    stall_left = 0;
    free_left  = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (free_left != 0) begin
        out_stall <= 1'b0;
        free_left--;
      end else begin
        out_stall <= 1'b0;
        free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(0, 6);
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("[query_text_lexer] ERROR");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned i = 0; i < DirectedLen; i++)
      feed_char(DirectedText[(DirectedLen-1-i)*8 +: 8], 1'b0);
    random_text();
    feed_ending();

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[query_text_lexer] OK");
    end else begin
      $display("[query_text_lexer] ERROR");
    end
    $finish;
  end

endmodule
